@@ rtl/core/keyed_point_table_radius_query_unit_macros.svh @@
// Assertion macros for the keyed point table radius query unit.
`ifndef KEYED_POINT_TABLE_RADIUS_QUERY_UNIT_MACROS_SVH
`define KEYED_POINT_TABLE_RADIUS_QUERY_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPTRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPTRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kptrq_pkg.sv @@
// Shared types and constants of the keyed point table radius query unit.
package kptrq_pkg;

    localparam int KEY_W   = 64;   // key port width
    localparam int COORD_W = 16;   // coordinate width
    localparam int RAD_W   = 15;   // radius width
    localparam int LIM_W   = 2 * RAD_W;    // radius squared
    localparam int SQ_W    = 32;   // one squared coordinate difference
    localparam int DIST_W  = SQ_W + 1;     // sum of two squares

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_RADIUS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

@@ rtl/core/kptrq_mem.sv @@
// Entry memory: one write port, one read port with registered read data.
module kptrq_mem #(
    parameter  int DEPTH = 32,
    parameter  int WIDTH = 96,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/keyed_point_table_radius_query_unit.sv @@
// Top level of the keyed point table radius query unit.
// The unit keeps an ordered table of up to TABLE_DEPTH points (key, x, y) in one
// synchronous memory and handles one command word at a time; a new command is
// taken whenever the sequencer is idle, even while the last result word still
// waits at the output register. Search, delete and radius query read the table
// through the memory port one entry per cycle, unless the output stalls,
// through a three-deep read/square/compare pipeline; a radius query or a miss
// closes in a final state. Delete then moves the later entries down one place
// at one memory read and one write per cycle. A stalled output freezes the scan.
// A radius query gives one word per point within range, the last one flagged,
// or a single not-found word.
`include "keyed_point_table_radius_query_unit_macros.svh"

module keyed_point_table_radius_query_unit #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [kptrq_pkg::KEY_W-1:0]     i_key,
    input  logic signed [kptrq_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [kptrq_pkg::COORD_W-1:0] i_pos_y,
    input  logic [kptrq_pkg::RAD_W-1:0]     i_radius,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [kptrq_pkg::KEY_W-1:0]     o_found_key,
    output logic signed [kptrq_pkg::COORD_W-1:0] o_found_x,
    output logic signed [kptrq_pkg::COORD_W-1:0] o_found_y,
    output logic                            o_last
);

    import kptrq_pkg::*;

    localparam int IW      = $clog2(TABLE_DEPTH);
    localparam int CW      = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = KEY_BITS + 2 * COORD_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INS   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FIN   = 5'b01000,
        S_SHIFT = 5'b10000
    } t_state;

    // control
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic r_issue, n_issue;
    logic r_p1_vld, n_p1_vld;
    logic r_p2_vld, n_p2_vld;
    logic r_pend_vld, n_pend_vld;
    logic r_sh_wvld, n_sh_wvld;
    logic r_out_vld;

    // command and pipeline payload
    t_cmd r_cmd, n_cmd;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic signed [COORD_W-1:0] r_px, n_px, r_py, n_py;
    logic [LIM_W-1:0] r_lim, n_lim;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic r_p1_last, n_p1_last;
    logic [IW-1:0] r_p1_idx, n_p1_idx;
    logic r_p2_last, n_p2_last;
    logic [IW-1:0] r_p2_idx, n_p2_idx;
    logic [KEY_BITS-1:0] r_p2_key, n_p2_key;
    logic signed [COORD_W-1:0] r_p2_x, n_p2_x, r_p2_y, n_p2_y;
    logic [SQ_W-1:0] r_sqx, n_sqx, r_sqy, n_sqy;
    logic [KEY_BITS-1:0] r_pend_key, n_pend_key;
    logic signed [COORD_W-1:0] r_pend_x, n_pend_x, r_pend_y, n_pend_y;
    logic [CW-1:0] r_sh_rd, n_sh_rd;
    logic [IW-1:0] r_sh_wa, n_sh_wa;

    // output register
    t_status r_out_status;
    logic [KEY_BITS-1:0] r_out_key;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic r_out_last;

    // memory port
    logic m_rd_en, m_wr_en;
    logic [IW-1:0] m_rd_addr, m_wr_addr;
    logic [ENTRY_W-1:0] m_wr_data, w_rdata;

    // result emission
    logic e_vld, e_last;
    t_status e_status;
    logic [KEY_BITS-1:0] e_key;
    logic signed [COORD_W-1:0] e_x, e_y;

    logic w_en;
    logic [KEY_BITS-1:0] w_rd_key;
    logic signed [COORD_W-1:0] w_rd_x, w_rd_y;
    logic signed [COORD_W:0] w_dx, w_dy;
    logic signed [2*COORD_W+1:0] w_dx2, w_dy2;
    logic [DIST_W-1:0] w_dist;
    logic w_in_range, w_key_hit;
    logic [IW-1:0] w_last_idx;
    logic [CW-1:0] w_cnt_m1, w_sh_prev;

    kptrq_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (m_rd_en),
        .i_rd_addr (m_rd_addr),
        .o_rd_data (w_rdata),
        .i_wr_en   (m_wr_en),
        .i_wr_addr (m_wr_addr),
        .i_wr_data (m_wr_data)
    );

    assign w_en = !r_out_vld || !i_out_stall;

    assign w_rd_key = w_rdata[ENTRY_W-1:2*COORD_W];
    assign w_rd_x   = w_rdata[2*COORD_W-1:COORD_W];
    assign w_rd_y   = w_rdata[COORD_W-1:0];

    assign w_dx  = $signed({w_rd_x[COORD_W-1], w_rd_x}) - $signed({r_px[COORD_W-1], r_px});
    assign w_dy  = $signed({w_rd_y[COORD_W-1], w_rd_y}) - $signed({r_py[COORD_W-1], r_py});
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;

    assign w_dist     = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_in_range = w_dist <= DIST_W'(r_lim);
    assign w_key_hit  = r_p2_key == r_key;

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_last_idx = w_cnt_m1[IW-1:0];
    assign w_sh_prev  = r_sh_rd - CW'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_issue    = r_issue;
        n_p1_vld   = r_p1_vld;
        n_p2_vld   = r_p2_vld;
        n_pend_vld = r_pend_vld;
        n_sh_wvld  = r_sh_wvld;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_px       = r_px;
        n_py       = r_py;
        n_lim      = r_lim;
        n_rd_idx   = r_rd_idx;
        n_p1_last  = r_p1_last;
        n_p1_idx   = r_p1_idx;
        n_p2_last  = r_p2_last;
        n_p2_idx   = r_p2_idx;
        n_p2_key   = r_p2_key;
        n_p2_x     = r_p2_x;
        n_p2_y     = r_p2_y;
        n_sqx      = r_sqx;
        n_sqy      = r_sqy;
        n_pend_key = r_pend_key;
        n_pend_x   = r_pend_x;
        n_pend_y   = r_pend_y;
        n_sh_rd    = r_sh_rd;
        n_sh_wa    = r_sh_wa;

        m_rd_en   = 1'b0;
        m_rd_addr = r_rd_idx;
        m_wr_en   = 1'b0;
        m_wr_addr = r_sh_wa;
        m_wr_data = w_rdata;

        e_vld    = 1'b0;
        e_status = ST_OK;
        e_key    = r_p2_key;
        e_x      = r_p2_x;
        e_y      = r_p2_y;
        e_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd      = t_cmd'(i_cmd);
                    n_key      = i_key[KEY_BITS-1:0];
                    n_px       = i_pos_x;
                    n_py       = i_pos_y;
                    n_lim      = LIM_W'(i_radius) * LIM_W'(i_radius);
                    n_rd_idx   = '0;
                    n_issue    = 1'b0;
                    n_p1_vld   = 1'b0;
                    n_p2_vld   = 1'b0;
                    n_pend_vld = 1'b0;
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        n_state = S_INS;
                    end else if (r_count == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                        n_issue = 1'b1;
                    end
                end
            end
            S_INS: begin
                if (w_en) begin
                    e_vld   = 1'b1;
                    e_key   = r_key;
                    n_state = S_IDLE;
                    if (r_count == CW'(TABLE_DEPTH)) begin
                        e_status = ST_FULL;
                        e_x      = '0;
                        e_y      = '0;
                    end else begin
                        e_x       = r_px;
                        e_y       = r_py;
                        m_wr_en   = 1'b1;
                        m_wr_addr = r_count[IW-1:0];
                        m_wr_data = {r_key, r_px, r_py};
                        n_count   = r_count + CW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (w_en) begin
                    // issue the next read
                    if (r_issue) begin
                        m_rd_en   = 1'b1;
                        m_rd_addr = r_rd_idx;
                        n_p1_vld  = 1'b1;
                        n_p1_idx  = r_rd_idx;
                        n_p1_last = r_rd_idx == w_last_idx;
                        n_rd_idx  = r_rd_idx + IW'(1);
                        if (r_rd_idx == w_last_idx) begin
                            n_issue = 1'b0;
                        end
                    end else begin
                        n_p1_vld = 1'b0;
                    end
                    // square the differences of the entry just read
                    n_p2_vld  = r_p1_vld;
                    n_p2_last = r_p1_last;
                    n_p2_idx  = r_p1_idx;
                    n_p2_key  = w_rd_key;
                    n_p2_x    = w_rd_x;
                    n_p2_y    = w_rd_y;
                    n_sqx     = w_dx2[SQ_W-1:0];
                    n_sqy     = w_dy2[SQ_W-1:0];
                    // evaluate
                    if (r_p2_vld) begin
                        if (r_cmd == CMD_RADIUS) begin
                            // keep one hit back so the final word can carry last
                            if (w_in_range) begin
                                if (r_pend_vld) begin
                                    e_vld  = 1'b1;
                                    e_key  = r_pend_key;
                                    e_x    = r_pend_x;
                                    e_y    = r_pend_y;
                                    e_last = 1'b0;
                                end
                                n_pend_vld = 1'b1;
                                n_pend_key = r_p2_key;
                                n_pend_x   = r_p2_x;
                                n_pend_y   = r_p2_y;
                            end
                            if (r_p2_last) begin
                                n_state = S_FIN;
                            end
                        end else if (w_key_hit) begin
                            e_vld    = 1'b1;
                            n_issue  = 1'b0;
                            n_p1_vld = 1'b0;
                            n_p2_vld = 1'b0;
                            if (r_cmd == CMD_DELETE) begin
                                if (r_p2_last) begin
                                    n_count = w_cnt_m1;
                                    n_state = S_IDLE;
                                end else begin
                                    n_state   = S_SHIFT;
                                    n_sh_rd   = CW'(r_p2_idx) + CW'(1);
                                    n_sh_wvld = 1'b0;
                                end
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else if (r_p2_last) begin
                            n_state = S_FIN;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle one place lower
                if (r_sh_wvld) begin
                    m_wr_en   = 1'b1;
                    m_wr_addr = r_sh_wa;
                    m_wr_data = w_rdata;
                end
                if (r_sh_rd < r_count) begin
                    m_rd_en   = 1'b1;
                    m_rd_addr = r_sh_rd[IW-1:0];
                    n_sh_rd   = r_sh_rd + CW'(1);
                    n_sh_wvld = 1'b1;
                    n_sh_wa   = w_sh_prev[IW-1:0];
                end else begin
                    n_sh_wvld = 1'b0;
                    if (!r_sh_wvld) begin
                        n_count = w_cnt_m1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (w_en) begin
                    e_vld   = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_RADIUS && r_pend_vld) begin
                        e_key = r_pend_key;
                        e_x   = r_pend_x;
                        e_y   = r_pend_y;
                    end else begin
                        e_status = ST_NOT_FOUND;
                        e_key    = (r_cmd == CMD_RADIUS) ? '0 : r_key;
                        e_x      = '0;
                        e_y      = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_issue    <= 1'b0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_sh_wvld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_issue    <= n_issue;
            r_p1_vld   <= n_p1_vld;
            r_p2_vld   <= n_p2_vld;
            r_pend_vld <= n_pend_vld;
            r_sh_wvld  <= n_sh_wvld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_px       <= n_px;
        r_py       <= n_py;
        r_lim      <= n_lim;
        r_rd_idx   <= n_rd_idx;
        r_p1_last  <= n_p1_last;
        r_p1_idx   <= n_p1_idx;
        r_p2_last  <= n_p2_last;
        r_p2_idx   <= n_p2_idx;
        r_p2_key   <= n_p2_key;
        r_p2_x     <= n_p2_x;
        r_p2_y     <= n_p2_y;
        r_sqx      <= n_sqx;
        r_sqy      <= n_sqy;
        r_pend_key <= n_pend_key;
        r_pend_x   <= n_pend_x;
        r_pend_y   <= n_pend_y;
        r_sh_rd    <= n_sh_rd;
        r_sh_wa    <= n_sh_wa;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (e_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_vld) begin
            r_out_status <= e_status;
            r_out_key    <= e_key;
            r_out_x      <= e_x;
            r_out_y      <= e_y;
            r_out_last   <= e_last;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_status    = r_out_status;
    assign o_found_key = KEY_W'(r_out_key);
    assign o_found_x   = r_out_x;
    assign o_found_y   = r_out_y;
    assign o_last      = r_out_last;

    `KPTRQ_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != S_IDLE, "accepted word did not start a command")
    `KPTRQ_ASSERT_NOW(a_emit_needs_room, i_clk, i_rst_n, e_vld, !r_out_vld || !i_out_stall, "result word overwrote a stalled output word")
    `KPTRQ_ASSERT_NOW(a_no_write_in_scan, i_clk, i_rst_n, r_state == S_SCAN, !m_wr_en, "memory write during table scan")
    `KPTRQ_ASSERT_NOW(a_shift_write_in_table, i_clk, i_rst_n, m_wr_en && r_state == S_SHIFT, CW'(m_wr_addr) + CW'(1) < r_count, "delete shift wrote past the table end")

endmodule

@@ sim/keyed_point_table_radius_query_unit_tb.sv @@
// Self-checking testbench for the keyed point table radius query unit.
module keyed_point_table_radius_query_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kptrq_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 6;
    localparam int TABLE_DEPTH      = 32;
    localparam int KEY_BITS         = 64;
    localparam int KEY_POOL_N       = 8;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int END_CYCLES       = 100;
    localparam int MAX_SRC_GAP      = 60;

    localparam logic [63:0] KEY_MASK = (~64'd0) >> (64 - KEY_BITS);
    localparam logic [63:0] KEY_ONES = ~64'd0;
    localparam logic [63:0] K_ALPHA  = 64'h0000_0041_4C50_4841;   // "ALPHA"
    localparam logic [63:0] K_EDGE   = 64'h0000_0000_4544_4745;   // "EDGE"
    localparam logic signed [15:0] COORD_MIN = 16'sh8000;
    localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
    localparam logic [14:0] RAD_MAX = 15'h7FFF;

    typedef struct {
        t_cmd               cmd;
        logic [63:0]        key;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        radius;
    } cmd_word_t;

    typedef struct {
        t_status            status;
        logic [63:0]        key;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } result_word_t;

    typedef struct {
        cmd_word_t    w;
        bit           typed;
        result_word_t r;
    } directed_row_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_cmd       = '0;
    logic [63:0]        i_key       = '0;
    logic signed [15:0] i_pos_x     = '0;
    logic signed [15:0] i_pos_y     = '0;
    logic [14:0]        i_radius    = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic [63:0]        o_found_key;
    logic signed [15:0] o_found_x;
    logic signed [15:0] o_found_y;
    logic               o_last;

    keyed_point_table_radius_query_unit #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .KEY_BITS   (KEY_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_radius   (i_radius),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_found_key(o_found_key),
        .o_found_x  (o_found_x),
        .o_found_y  (o_found_y),
        .o_last     (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the point table
    logic [63:0]        pt_key [TABLE_DEPTH];
    logic signed [15:0] pt_x   [TABLE_DEPTH];
    logic signed [15:0] pt_y   [TABLE_DEPTH];
    int                 pt_count = 0;

    result_word_t  predicted_words[$];
    result_word_t  expected_words[$];
    directed_row_t directed_table[$];
    logic [63:0]   key_pool [KEY_POOL_N];

    int   mismatch_count = 0;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   quiet_cycles   = 0;
    logic sink_holding   = 1'b0;
    event sink_hold_go;

    function automatic result_word_t mk_result(t_status st, logic [63:0] k,
                                               logic signed [15:0] x, logic signed [15:0] y,
                                               logic lst);
        result_word_t r;
        r.status = st;
        r.key    = k;
        r.x      = x;
        r.y      = y;
        r.last   = lst;
        return r;
    endfunction

    // Append one word to the words predicted for the current command
    function automatic void predict(result_word_t r);
        predicted_words.insert(predicted_words.size(), r);
    endfunction

    // Apply one command to the shadow table and queue the words it yields
    function automatic void table_apply(cmd_word_t w);
        logic [63:0] k;
        int          hit;
        int          i;
        longint      dx;
        longint      dy;
        longint      lim;
        k   = w.key & KEY_MASK;
        hit = -1;
        for (i = pt_count - 1; i >= 0; i--)
            if (pt_key[i] == k) hit = i;
        case (w.cmd)
            CMD_INSERT: begin
                if (pt_count >= TABLE_DEPTH) begin
                    predict(mk_result(ST_FULL, k, '0, '0, 1'b1));
                end else begin
                    pt_key[pt_count] = k;
                    pt_x[pt_count]   = w.x;
                    pt_y[pt_count]   = w.y;
                    pt_count++;
                    predict(mk_result(ST_OK, k, w.x, w.y, 1'b1));
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                if (hit < 0) begin
                    predict(mk_result(ST_NOT_FOUND, k, '0, '0, 1'b1));
                end else begin
                    predict(mk_result(ST_OK, pt_key[hit], pt_x[hit], pt_y[hit], 1'b1));
                    if (w.cmd == CMD_DELETE) begin
                        // close the gap, keep table order
                        for (i = hit; i + 1 < pt_count; i++) begin
                            pt_key[i] = pt_key[i + 1];
                            pt_x[i]   = pt_x[i + 1];
                            pt_y[i]   = pt_y[i + 1];
                        end
                        pt_count--;
                    end
                end
            end
            default: begin
                lim = longint'(w.radius) * longint'(w.radius);
                for (i = 0; i < pt_count; i++) begin
                    dx = longint'(pt_x[i]) - longint'(w.x);
                    dy = longint'(pt_y[i]) - longint'(w.y);
                    if (dx * dx + dy * dy <= lim)
                        predict(mk_result(ST_OK, pt_key[i], pt_x[i], pt_y[i], 1'b0));
                end
                if (predicted_words.size() == 0)
                    predict(mk_result(ST_NOT_FOUND, '0, '0, '0, 1'b1));
                else
                    predicted_words[predicted_words.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void add_row(t_cmd c, logic [63:0] k, logic signed [15:0] x,
                                    logic signed [15:0] y, logic [14:0] rad, bit typed,
                                    t_status st, logic [63:0] fk, logic signed [15:0] fx,
                                    logic signed [15:0] fy);
        directed_row_t row;
        row.w.cmd    = c;
        row.w.key    = k;
        row.w.x      = x;
        row.w.y      = y;
        row.w.radius = rad;
        row.typed    = typed;
        row.r        = mk_result(st, fk, fx, fy, 1'b1);
        directed_table.insert(directed_table.size(), row);
    endfunction

    function automatic logic signed [15:0] near_coord();
        return 16'($urandom_range(80)) - 16'sd40;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        pick;
        int        ins_pct;
        ins_pct = (pt_count >= TABLE_DEPTH - 8) ? 15 : 35;
        pick    = $urandom_range(99);
        if (pick < ins_pct)           w.cmd = CMD_INSERT;
        else if (pick < ins_pct + 22) w.cmd = CMD_SEARCH;
        else if (pick < ins_pct + 44) w.cmd = CMD_DELETE;
        else                          w.cmd = CMD_RADIUS;
        // mostly pool keys so lookups hit; now and then a fresh key
        if ($urandom_range(9) == 0) w.key = {$urandom, $urandom};
        else                        w.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
        w.x = ($urandom_range(99) < 15) ? 16'($urandom) : near_coord();
        w.y = ($urandom_range(99) < 15) ? 16'($urandom) : near_coord();
        case ($urandom_range(19))
            0:       w.radius = '0;
            1:       w.radius = RAD_MAX;
            2, 3, 4: w.radius = 15'($urandom_range(32767));
            default: w.radius = 15'($urandom_range(80));
        endcase
        return w;
    endfunction

    function automatic void cmp_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ERROR %s expected %h actual %h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    task automatic send_word(input cmd_word_t w, input bit typed, input result_word_t typed_res);
        int gap;
        gap = 0;
        while (gap < MAX_SRC_GAP && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= w.cmd;
        i_key      <= w.key;
        i_pos_x    <= w.x;
        i_pos_y    <= w.y;
        i_radius   <= w.radius;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        table_apply(w);
        if (typed) expected_words.insert(expected_words.size(), typed_res);
        else foreach (predicted_words[i])
            expected_words.insert(expected_words.size(), predicted_words[i]);
        predicted_words.delete();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        result_word_t none;
        none = mk_result(ST_OK, '0, '0, '0, 1'b0);
        repeat (n) send_word(random_word(), 1'b0, none);
    endtask

    // Output stall: random per phase, or a long hold on request
    always @(posedge i_clk)
        i_out_stall <= sink_holding || ($urandom_range(99) < sink_stall_pct);

    initial begin
        forever begin
            @(sink_hold_go);
            sink_holding <= 1'b1;
            repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
            sink_holding <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        result_word_t want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t ERROR unexpected word expected none actual status %0d key %h",
                         $time, o_status, o_found_key);
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                cmp_field("status", 64'(want.status), 64'(o_status));
                cmp_field("found_key", want.key, o_found_key);
                cmp_field("found_x", 64'(want.x), 64'(o_found_x));
                cmp_field("found_y", 64'(want.y), 64'(o_found_y));
                cmp_field("last", 64'(want.last), 64'(o_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        cmd_word_t    w;
        result_word_t none;
        none = mk_result(ST_OK, '0, '0, '0, 1'b0);
        key_pool[0] = '0;
        key_pool[1] = KEY_ONES;
        key_pool[2] = K_ALPHA;
        for (int i = 3; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

        // empty table, extremes, duplicates, exact radius boundary, head delete
        add_row(CMD_SEARCH, '0, '0, '0, '0, 1, ST_NOT_FOUND, '0, '0, '0);
        add_row(CMD_DELETE, KEY_ONES, '0, '0, '0, 1, ST_NOT_FOUND, KEY_ONES, '0, '0);
        add_row(CMD_RADIUS, '0, '0, '0, RAD_MAX, 1, ST_NOT_FOUND, '0, '0, '0);
        add_row(CMD_INSERT, '0, COORD_MIN, COORD_MAX, '0, 1, ST_OK, '0, COORD_MIN, COORD_MAX);
        add_row(CMD_INSERT, KEY_ONES, COORD_MAX, COORD_MIN, RAD_MAX, 1, ST_OK, KEY_ONES,
                COORD_MAX, COORD_MIN);
        add_row(CMD_INSERT, K_ALPHA, '0, '0, '0, 1, ST_OK, K_ALPHA, '0, '0);
        add_row(CMD_INSERT, K_ALPHA, 16'sd5, -16'sd5, '0, 1, ST_OK, K_ALPHA, 16'sd5, -16'sd5);
        add_row(CMD_INSERT, K_EDGE, 16'sd3, 16'sd4, '0, 1, ST_OK, K_EDGE, 16'sd3, 16'sd4);
        add_row(CMD_SEARCH, K_ALPHA, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_SEARCH, KEY_ONES, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_RADIUS, '0, '0, '0, 15'd5, 0, ST_OK, '0, '0, '0);
        add_row(CMD_RADIUS, '0, '0, '0, 15'd4, 0, ST_OK, '0, '0, '0);
        add_row(CMD_RADIUS, '0, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_RADIUS, '0, COORD_MIN, COORD_MIN, RAD_MAX, 0, ST_OK, '0, '0, '0);
        add_row(CMD_RADIUS, '0, COORD_MIN, COORD_MAX, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_RADIUS, '0, '0, '0, RAD_MAX, 0, ST_OK, '0, '0, '0);
        add_row(CMD_DELETE, K_ALPHA, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_SEARCH, K_ALPHA, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_DELETE, '0, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_DELETE, K_ALPHA, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_DELETE, K_ALPHA, '0, '0, '0, 1, ST_NOT_FOUND, K_ALPHA, '0, '0);
        add_row(CMD_SEARCH, K_EDGE, '0, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(CMD_RADIUS, '0, COORD_MAX, COORD_MIN, 15'd1, 0, ST_OK, '0, '0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_table[r])
            send_word(directed_table[r].w, directed_table[r].typed, directed_table[r].r);
        wait_drained();

        // back to back, with the output held off long enough to back up the input
        src_idle_pct   = 0;
        sink_stall_pct <= 0;
        -> sink_hold_go;
        run_random(25);
        wait_drained();

        // sender idling; fill the table past full, then one largest-radius query from the origin
        src_idle_pct = 73;
        while (pt_count < TABLE_DEPTH) begin
            w     = random_word();
            w.cmd = CMD_INSERT;
            w.x   = near_coord();
            w.y   = near_coord();
            send_word(w, 1'b0, none);
        end
        repeat (2) begin
            w     = random_word();
            w.cmd = CMD_INSERT;
            send_word(w, 1'b0, none);
        end
        w        = random_word();
        w.cmd    = CMD_RADIUS;
        w.x      = '0;
        w.y      = '0;
        w.radius = RAD_MAX;
        send_word(w, 1'b0, none);
        run_random(15);
        wait_drained();

        src_idle_pct   = 0;
        sink_stall_pct <= 73;
        run_random(25);
        wait_drained();

        src_idle_pct   = 38;
        sink_stall_pct <= 38;
        run_random(25);
        wait_drained();

        sink_stall_pct <= 0;
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ keyed_point_table_radius_query_unit.f @@
+incdir+rtl/core
rtl/core/kptrq_pkg.sv
rtl/core/kptrq_mem.sv
rtl/core/keyed_point_table_radius_query_unit.sv
sim/keyed_point_table_radius_query_unit_tb.sv
